>>> rtl/line_sensor_position_calibrate_macros.svh
// Assertion macros shared by the line sensor position blocks.
`ifndef LINE_SENSOR_POSITION_CALIBRATE_MACROS_SVH
`define LINE_SENSOR_POSITION_CALIBRATE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LSPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define LSPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/lspc_pkg.sv
// Package with the constants, types and helpers of the line sensor position block.
`default_nettype none
package lspc_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int SAMPLE_BITS  = 10;

  localparam int CH_W      = 4;
  localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VALUE_W   = 10;
  localparam int RANGE_W   = 14;
  localparam int POS_W     = 11;
  localparam int SCALED_W  = 15;
  localparam int SUM_W     = 14;
  localparam int CNT_W     = 5;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [SUM_W-1:0]       SUM_MAX    = '1;
  localparam logic [CNT_W-1:0]       COUNT_MAX  = '1;
  localparam logic [CH_W:0]          CH_LIMIT   = (CH_W+1)'(NUM_CHANNELS);

  localparam logic [POS_W-1:0]  POS_LOW       = 11'd100;
  localparam logic [POS_W-1:0]  WEIGHT_STEP   = 11'd100;
  localparam logic [10:0]       POS_SPAN      = 11'd1500;
  localparam logic [RANGE_W-1:0] RANGE_RESET  = 14'd100;

  // Serial divider: dividend and product width, and step count.
  localparam int DIV_W     = 26;
  localparam int DIVISOR_W = 11;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DIV_W);

  // Division by the 1500-wide position span as a reciprocal multiply:
  // floor(x / 1500) equals (x * SPAN_RECIP) >> SPAN_SHIFT for every x below 2^DIV_W.
  localparam int RECIP_W    = 27;
  localparam int SPAN_SHIFT = 37;
  localparam logic [RECIP_W-1:0] SPAN_RECIP = 27'd91625969;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input kind codes.
  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_CALIB    = 2'd1;
  localparam logic [1:0] KIND_POSITION = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    OP_CLR,
    OP_CAL,
    OP_POS,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic                   ch_ok;
    logic [CH_IDX_W-1:0]    ch_idx;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] value;
    logic                   eos;
  } cmd_t;

  // Weight of a channel in the centroid: (channel + 1) * 100.
  function automatic logic [POS_W-1:0] weight_of(input logic [CH_W-1:0] ch);
    logic [POS_W-1:0] idx;
    idx = POS_W'(ch) + POS_W'(1);
    return idx * WEIGHT_STEP;
  endfunction

endpackage
`default_nettype wire

>>> rtl/line_sensor_position_calibrate.sv
// A word that does not end a sweep goes through the queue, then the output register.
// A sweep-end word is scaled, and first averaged if the sweep had hits: the centroid
// runs through a 26-step serial divider, the scaling through one reciprocal multiply.
// Throughput: one word per cycle without output stalls; a sweep end holds the back end.
// Reset (rst_n, synchronous, active low) empties the queue and result register,
// sets all calibration extremes and thresholds, accumulators and range to reset values.
`default_nettype none
module line_sensor_position_calibrate (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration: half span of the scaled output.
  input  wire logic                            cfg_wr_en,
  input  wire logic [lspc_pkg::RANGE_W-1:0]    cfg_wr_data,
  // Input words.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [lspc_pkg::CH_W-1:0]       in_channel,
  input  wire logic [lspc_pkg::VALUE_W-1:0]    in_sample_value,
  input  wire logic                            in_end_of_sweep,
  // Result words.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_above_threshold,
  output logic                                 out_position_ready,
  output logic                                 out_line_seen,
  output logic [lspc_pkg::POS_W-1:0]           out_position,
  output logic signed [lspc_pkg::SCALED_W-1:0] out_scaled_position
);
  import lspc_pkg::*;

  // The range register is to be written by the user only while the block is idle (the block
  // does not enforce this), so the back end can read it directly during the scaling steps.
  logic [RANGE_W-1:0] range_r;
  logic               cmd_valid;
  logic               cmd_pop;
  cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_RESET;
    end else if (cfg_wr_en) begin
      range_r <= cfg_wr_data;
    end
  end

  // The front end decodes each word and queues it; the queue holds up to two words
  // while the back end works through a sweep-end division, then stalls the input.
  lspc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .in_end_of_sweep (in_end_of_sweep),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  // The back end owns the calibration tables and sweep accumulators. It takes
  // one command at a time and holds its result in an output register; while a
  // stalled result waits, the front end takes words until its queue is full.
  lspc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_range           (range_r),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_pop             (cmd_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_above_threshold (out_above_threshold),
    .out_position_ready  (out_position_ready),
    .out_line_seen       (out_line_seen),
    .out_position        (out_position),
    .out_scaled_position (out_scaled_position)
  );

endmodule
`default_nettype wire

>>> rtl/lspc_front.sv
// Front end: accepts input words, decodes their kind and queues the commands.
`default_nettype none
module lspc_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [lspc_pkg::CH_W-1:0]      in_channel,
  input  wire logic [lspc_pkg::VALUE_W-1:0]   in_sample_value,
  input  wire logic                           in_end_of_sweep,
  output logic                                cmd_valid,
  output lspc_pkg::cmd_t                      cmd,
  input  wire logic                           cmd_pop
);
  import lspc_pkg::*;
  `include "line_sensor_position_calibrate_macros.svh"

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  cmd_t              dec;

  // Decode the incoming word into a command.
  always_comb begin
    dec.ch_ok   = {1'b0, in_channel} < CH_LIMIT;
    dec.ch_idx  = CH_IDX_W'(in_channel);
    dec.channel = in_channel;
    dec.value   = SAMPLE_BITS'(in_sample_value) & SAMPLE_MAX;
    dec.eos     = 1'b0;
    unique case (in_kind)
      KIND_CLEAR:    dec.op = OP_CLR;
      KIND_CALIB:    dec.op = OP_CAL;
      KIND_POSITION: begin
        dec.op  = OP_POS;
        dec.eos = in_end_of_sweep;
      end
      KIND_UNUSED:   dec.op = OP_NOP;
      default:       dec.op = OP_NOP;
    endcase
  end

  assign in_stall  = (count_r == QCNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  `LSPC_ASSERT(a_count_bound, count_r <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `LSPC_ASSERT(a_pop_nonempty, cmd_pop |-> count_r != '0, "command popped from empty queue")
  `LSPC_ASSERT(a_push_grows, (push && !cmd_pop) |=> count_r == $past(count_r) + QCNT_W'(1),
               "queue count did not grow on push")

endmodule
`default_nettype wire

>>> rtl/lspc_back.sv
// Back end: calibration tables, sweep accumulation, serial divider and result register.
`default_nettype none
module lspc_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [lspc_pkg::RANGE_W-1:0]    cfg_range,
  input  wire logic                            cmd_valid,
  input  wire lspc_pkg::cmd_t                  cmd,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_above_threshold,
  output logic                                 out_position_ready,
  output logic                                 out_line_seen,
  output logic [lspc_pkg::POS_W-1:0]           out_position,
  output logic signed [lspc_pkg::SCALED_W-1:0] out_scaled_position
);
  import lspc_pkg::*;
  `include "line_sensor_position_calibrate_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV1  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_RECIP = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] min_r [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] max_r [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] thr_r [NUM_CHANNELS];
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [POS_W-1:0]       held_r, held_nxt;
  logic [POS_W-1:0]       p_r, p_nxt;
  logic                   seen_r, seen_nxt;
  logic                   above_r, above_nxt;
  logic                   neg_r, neg_nxt;
  logic [DIV_W-1:0]       dq_r, dq_nxt;
  logic [DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]   dvs_r, dvs_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;

  logic                   out_valid_r;
  logic                   out_above_r, out_ready_r, out_seen_r;
  logic [POS_W-1:0]       out_pos_r;
  logic [SCALED_W-1:0]    out_scaled_r;

  logic                   out_free;
  logic                   load_simple, load_final;
  logic                   cal_we, clr_we;

  // Per-item datapath signals.
  logic [SAMPLE_BITS-1:0] cur_min, cur_max, cur_thr, new_min, new_max, new_thr;
  logic [SAMPLE_BITS:0]   mid_sum;
  logic                   above, hit;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_hit;
  logic [CNT_W-1:0]       cnt_hit;

  // Divider step.
  logic [DIVISOR_W:0]     trial;
  logic                   ge;
  logic [DIVISOR_W-1:0]   rem_step;

  // Scaling.
  logic [POS_W-1:0]       mag;
  logic [RANGE_W:0]       range2;
  logic [DIV_W-1:0]       prod;
  logic [DIV_W+RECIP_W-1:0] span_prod;
  logic signed [17:0]     q_s, r_s, v_s;
  logic [SCALED_W-1:0]    scaled;

  assign out_free = !out_valid_r || !out_stall;
  assign cmd_pop  = cmd_valid && (state_r == ST_IDLE) && out_free;

  // Calibration and position sample evaluation.
  always_comb begin
    cur_min = min_r[cmd.ch_idx];
    cur_max = max_r[cmd.ch_idx];
    cur_thr = thr_r[cmd.ch_idx];
    new_min = (cmd.value < cur_min) ? cmd.value : cur_min;
    new_max = (cmd.value > cur_max) ? cmd.value : cur_max;
    mid_sum = {1'b0, new_min} + {1'b0, new_max};
    new_thr = mid_sum[SAMPLE_BITS:1];
    above   = cmd.ch_ok && (cmd.value > cur_thr);
    hit     = above && (cnt_r < COUNT_MAX);
    sum_add = {1'b0, sum_r} + (SUM_W+1)'(weight_of(cmd.channel));
    sum_hit = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    cnt_hit = cnt_r + CNT_W'(1);
  end

  assign cal_we = cmd_pop && (cmd.op == OP_CAL) && cmd.ch_ok;
  assign clr_we = cmd_pop && (cmd.op == OP_CLR);

  // One restoring division step per cycle.
  always_comb begin
    trial    = {rem_r, dq_r[DIV_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    rem_step = ge ? DIVISOR_W'(trial - {1'b0, dvs_r}) : trial[DIVISOR_W-1:0];
  end

  // Map onto -range..+range (p in 100..1600): +-|p-100|*2*range/1500 - range, clamped.
  always_comb begin
    mag       = (p_r < POS_LOW) ? (POS_LOW - p_r) : (p_r - POS_LOW);
    range2    = {cfg_range, 1'b0};
    prod      = {{(DIV_W-POS_W){1'b0}}, mag} * {{(DIV_W-RANGE_W-1){1'b0}}, range2};
    span_prod = {{RECIP_W{1'b0}}, dq_r} * {{DIV_W{1'b0}}, SPAN_RECIP};
    q_s       = $signed({1'b0, dq_r[16:0]});
    r_s       = $signed({4'd0, cfg_range});
    v_s       = neg_r ? (-q_s - r_s) : (q_s - r_s);
    if (v_s < -18'sd16384) begin
      scaled = SCALED_W'(-18'sd16384);
    end else if (v_s > 18'sd16383) begin
      scaled = SCALED_W'(18'sd16383);
    end else begin
      scaled = SCALED_W'(v_s);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    held_nxt    = held_r;
    p_nxt       = p_r;
    seen_nxt    = seen_r;
    above_nxt   = above_r;
    neg_nxt     = neg_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    step_nxt    = step_r;
    load_simple = 1'b0;
    load_final  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          if (cmd.op == OP_POS) begin
            if (hit) begin
              sum_nxt = sum_hit;
              cnt_nxt = cnt_hit;
            end
            if (cmd.eos) begin
              above_nxt = above;
              sum_nxt   = '0;
              cnt_nxt   = '0;
              seen_nxt  = hit || (cnt_r != '0);
              if (hit || (cnt_r != '0)) begin
                dq_nxt    = DIV_W'(hit ? sum_hit : sum_r);
                dvs_nxt   = DIVISOR_W'(hit ? cnt_hit : cnt_r);
                rem_nxt   = '0;
                step_nxt  = '0;
                state_nxt = ST_DIV1;
              end else begin
                p_nxt     = held_r;
                state_nxt = ST_MUL;
              end
            end else begin
              load_simple = 1'b1;
            end
          end else begin
            load_simple = 1'b1;
          end
        end
      end
      ST_DIV1: begin
        dq_nxt   = {dq_r[DIV_W-2:0], ge};
        rem_nxt  = rem_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_STEPS - STEP_W'(1)) begin
          p_nxt     = POS_W'({dq_r[DIV_W-2:0], ge});
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        held_nxt  = p_r;
        neg_nxt   = p_r < POS_LOW;
        dq_nxt    = prod;
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        // Quotient of the product by the 1500-wide span, in one multiply.
        dq_nxt    = DIV_W'(span_prod[DIV_W+RECIP_W-1:SPAN_SHIFT]);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_final = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      if (load_simple || load_final) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    seen_r  <= seen_nxt;
    above_r <= above_nxt;
    neg_r   <= neg_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    step_r  <= step_nxt;
    if (load_simple) begin
      out_above_r  <= (cmd.op == OP_POS) && above;
      out_ready_r  <= 1'b0;
      out_seen_r   <= 1'b0;
      out_pos_r    <= '0;
      out_scaled_r <= '0;
    end else if (load_final) begin
      out_above_r  <= above_r;
      out_ready_r  <= 1'b1;
      out_seen_r   <= seen_r;
      out_pos_r    <= p_r;
      out_scaled_r <= scaled;
    end
  end

  // Calibration tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        min_r[i] <= SAMPLE_MAX;
        max_r[i] <= '0;
        thr_r[i] <= '0;
      end
    end else if (clr_we) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        min_r[i] <= SAMPLE_MAX;
        max_r[i] <= '0;
      end
    end else if (cal_we) begin
      min_r[cmd.ch_idx] <= new_min;
      max_r[cmd.ch_idx] <= new_max;
      thr_r[cmd.ch_idx] <= new_thr;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_above_threshold = out_above_r;
  assign out_position_ready  = out_ready_r;
  assign out_line_seen       = out_seen_r;
  assign out_position        = out_pos_r;
  assign out_scaled_position = $signed(out_scaled_r);

  `LSPC_ASSERT(a_idle_fields_zero,
               (out_valid_r && !out_ready_r) |->
               (!out_seen_r && out_pos_r == '0 && out_scaled_r == '0),
               "non-final word carries position fields")
  `LSPC_ASSERT(a_empty_sum_zero, (cnt_r == '0) |-> (sum_r == '0),
               "weight sum nonzero with no hits")
  `LSPC_ASSERT(a_step_bound, (state_r == ST_DIV1) |-> (step_r < DIV_STEPS),
               "divider ran past its step count")

endmodule
`default_nettype wire
